FILE: rtl/core/lert_pkg.sv
// Shared types and sizes for the longest equal run tracker.
// No dependencies; imported by every module of the block but lert_ram.
package lert_pkg;

  localparam int MAX_LENGTH = 4096;
  localparam int TREE_NODES = 16384;
  localparam int LEN_W      = 13;
  localparam int POS_W      = 12;
  localparam int CHAR_W     = 8;
  localparam int NODE_W     = 14;
  localparam int MAX_DEPTH  = 12;
  localparam int LVL_W      = 4;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LENGTH);
  localparam logic [NODE_W-1:0] SWEEP_LAST = NODE_W'(TREE_NODES - 1);
  localparam logic OP_CLEAR = 1'b0;

  // Tree node word; an entry with valid low reads as an all-equal span
  typedef struct packed {
    logic             valid;
    logic [LEN_W-1:0] best;
    logic [LEN_W-1:0] head;
    logic [LEN_W-1:0] tail;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

  typedef struct packed {
    logic cfg_wr;
    logic cap_item;
    logic sweep_start;
    logic sweep_step;
    logic root_len;
    logic desc_init;
    logic desc_step;
    logic char_wr;
    logic rd_a;
    logic rd_b;
    logic merge;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic op_set;
    logic pos_err;
    logic sweep_last;
    logic leaf;
    logic depth_zero;
    logic lvl_zero;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/longest_equal_run_tracker_top.sv
// Top level of the longest equal run tracker: controller plus datapath.
// Depends on lert_pkg, lert_ctrl, lert_dpath.
//
// One item at a time. A set item is accepted, walks down the tree level
// by level to the leaf, where its character is written, climbs back up
// with two registered node RAM reads and one merge write per level, and
// ends with the reply. A clear item, a length write and reset each run a
// clearing pass over the 16384 entries of the node RAM, one entry a cycle,
// during which no item is taken; a clear replies when the pass ends. An
// out-of-range set goes from its accept straight to the reply. The result
// register lets the next word in while a reply waits.
module longest_equal_run_tracker_top
  import lert_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [POS_W-1:0]  position,
  input  logic [CHAR_W-1:0] character,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LEN_W-1:0]  longest_run,
  output logic              index_error,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LEN_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  lert_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lert_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .operation   (operation),
    .position    (position),
    .character   (character),
    .cfg_data    (cfg_data),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .longest_run (longest_run),
    .index_error (index_error)
  );

  // a reported run is never empty and never longer than MAX_LENGTH
  a_run_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (longest_run != '0) && (longest_run <= LEN_RESET))
    else $error("longest_run out of range");

  // an accepted word leaves both readies low in the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready && !cfg_ready)
    else $error("ready high right after an item");

  // a length write starts the clearing pass
  a_busy_after_cfg: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> !in_ready && !cfg_ready)
    else $error("ready high right after a length write");

  // a clear item never flags an index error
  a_clear_no_err: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_CLEAR)) |=> !(out_valid && index_error)
      || $past(out_valid && !out_ready))
    else $error("clear flagged an error");

endmodule

FILE: rtl/core/lert_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module lert_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word, read one word a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/core/lert_ctrl.sv
// Sequencer for the run tracker: sweep, descent, merge walk, reply.
// Depends on lert_pkg; drives the datapath by cmd_t, reads stat_t.
module lert_ctrl
  import lert_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  cfg_valid,
  output logic  cfg_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SWEEP = 3'd1;
  localparam logic [2:0] S_DESC  = 3'd2;
  localparam logic [2:0] S_RA    = 3'd3;
  localparam logic [2:0] S_RB    = 3'd4;
  localparam logic [2:0] S_MERGE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state, state_next;
  logic       reply, reply_next;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;

  // next state and commands
  always_comb begin
    state_next = state;
    reply_next = reply;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_wr      = 1'b1;
          cmd.sweep_start = 1'b1;
          reply_next      = 1'b0;
          state_next      = S_SWEEP;
        end else if (in_valid) begin
          cmd.cap_item = 1'b1;
          priority if (!stat.op_set) begin
            cmd.sweep_start = 1'b1;
            reply_next      = 1'b1;
            state_next      = S_SWEEP;
          end else if (stat.pos_err) begin
            state_next = S_DONE;
          end else begin
            cmd.desc_init = 1'b1;
            state_next    = S_DESC;
          end
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          cmd.root_len = 1'b1;
          state_next   = reply ? S_DONE : S_IDLE;
        end
      end
      S_DESC: begin
        if (stat.leaf) begin
          cmd.char_wr = 1'b1;
          state_next  = stat.depth_zero ? S_DONE : S_RA;
        end else begin
          cmd.desc_step = 1'b1;
        end
      end
      S_RA: begin
        cmd.rd_a   = 1'b1;
        state_next = S_RB;
      end
      S_RB: begin
        cmd.rd_b   = 1'b1;
        state_next = S_MERGE;
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = stat.lvl_zero ? S_DONE : S_RA;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state registers; reset runs the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP;
      reply <= 1'b0;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

endmodule

FILE: rtl/core/lert_dpath.sv
// Datapath: length register, char and node RAMs, path stack, merge logic.
// Depends on lert_pkg and lert_ram.
module lert_dpath
  import lert_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic              operation,
  input  logic [POS_W-1:0]  position,
  input  logic [CHAR_W-1:0] character,
  input  logic [LEN_W-1:0]  cfg_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [LEN_W-1:0]  longest_run,
  output logic              index_error
);

  logic [LEN_W-1:0]  string_length;
  logic [LEN_W-1:0]  len_eff;
  logic [NODE_W-1:0] sweep_cnt;
  logic [POS_W-1:0]  pos_reg;
  logic [CHAR_W-1:0] ch_reg;
  logic              err_reg;
  logic [LEN_W-1:0]  root_best;

  logic [POS_W-1:0]  lo, hi, mid_d;
  logic [NODE_W-1:0] node;
  logic [LVL_W-1:0]  depth, lvl;
  logic [POS_W-1:0]  stk_lo   [MAX_DEPTH];
  logic [POS_W-1:0]  stk_hi   [MAX_DEPTH];
  logic [NODE_W-1:0] stk_node [MAX_DEPTH];

  logic [POS_W-1:0]  cur_lo, cur_hi, cur_mid;
  logic [NODE_W-1:0] cur_node;
  logic [LEN_W-1:0]  len_a, len_b, joined;
  node_t             a_reg, ca, cb, merged, node_rd, node_wdata;
  logic [CHAR_W-1:0] cm_reg, char_rd, char_wdata;
  logic [NODE_W-1:0] node_waddr, node_raddr;
  logic [POS_W-1:0]  char_waddr, char_raddr;

  // clamp the length register to 1..MAX_LENGTH
  always_comb begin
    priority if (string_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (string_length > LEN_RESET) begin
      len_eff = LEN_RESET;
    end else begin
      len_eff = string_length;
    end
  end

  assign mid_d    = lo + ((hi - lo) >> 1);
  assign cur_lo   = stk_lo[lvl];
  assign cur_hi   = stk_hi[lvl];
  assign cur_node = stk_node[lvl];
  assign cur_mid  = cur_lo + ((cur_hi - cur_lo) >> 1);
  assign len_a    = {1'b0, cur_mid - cur_lo} + LEN_W'(1);
  assign len_b    = {1'b0, cur_hi - cur_mid};

  // children that were never written since the sweep span all-equal runs
  always_comb begin
    ca = a_reg.valid ? a_reg : node_t'{1'b1, len_a, len_a, len_a};
    cb = node_rd.valid ? node_rd : node_t'{1'b1, len_b, len_b, len_b};
  end

  // merge two children, joining runs when the split characters match
  assign joined = ca.tail + cb.head;
  always_comb begin
    merged.valid = 1'b1;
    merged.best  = (ca.best > cb.best) ? ca.best : cb.best;
    merged.head  = ca.head;
    merged.tail  = cb.tail;
    if (cm_reg == char_rd) begin
      if (joined > merged.best) begin
        merged.best = joined;
      end
      if (ca.head == len_a) begin
        merged.head = len_a + cb.head;
      end
      if (cb.tail == len_b) begin
        merged.tail = len_b + ca.tail;
      end
    end
  end

  // RAM port selection
  always_comb begin
    node_waddr = cmd.sweep_step ? sweep_cnt : cur_node;
    node_wdata = cmd.sweep_step ? node_t'('0) : merged;
    node_raddr = cmd.rd_a ? {cur_node[NODE_W-2:0], 1'b1}
                          : ({cur_node[NODE_W-2:0], 1'b0} + NODE_W'(2));
    char_waddr = cmd.sweep_step ? sweep_cnt[POS_W-1:0] : pos_reg;
    char_wdata = cmd.sweep_step ? '0 : ch_reg;
    char_raddr = cmd.rd_a ? cur_mid : cur_mid + POS_W'(1);
  end

  lert_ram #(.WIDTH(NODE_BITS), .DEPTH(TREE_NODES)) u_node_ram (
    .clk     (clk),
    .wr_en   (cmd.sweep_step || cmd.merge),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_addr (node_raddr),
    .rd_data (node_rd)
  );

  lert_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LENGTH)) u_char_ram (
    .clk     (clk),
    .wr_en   (cmd.sweep_step || cmd.char_wr),
    .wr_addr (char_waddr),
    .wr_data (char_wdata),
    .rd_addr (char_raddr),
    .rd_data (char_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      string_length <= LEN_RESET;
      sweep_cnt     <= '0;
      out_valid     <= 1'b0;
      root_best     <= LEN_RESET;
    end else begin
      if (cmd.cfg_wr) begin
        string_length <= cfg_data;
      end
      if (cmd.sweep_start) begin
        sweep_cnt <= '0;
      end else if (cmd.sweep_step) begin
        sweep_cnt <= sweep_cnt + NODE_W'(1);
      end
      if (cmd.root_len) begin
        root_best <= len_eff;
      end else if (cmd.merge && lvl == '0) begin
        root_best <= merged.best;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item, walk and result registers
  always_ff @(posedge clk) begin
    if (cmd.cap_item) begin
      pos_reg <= position;
      ch_reg  <= character;
      err_reg <= operation && ({1'b0, position} >= len_eff);
    end
    if (cmd.desc_init) begin
      lo    <= '0;
      hi    <= POS_W'(len_eff - LEN_W'(1));
      node  <= '0;
      depth <= '0;
    end else if (cmd.desc_step) begin
      stk_lo[depth]   <= lo;
      stk_hi[depth]   <= hi;
      stk_node[depth] <= node;
      depth           <= depth + LVL_W'(1);
      if (pos_reg <= mid_d) begin
        hi   <= mid_d;
        node <= {node[NODE_W-2:0], 1'b1};
      end else begin
        lo   <= mid_d + POS_W'(1);
        node <= {node[NODE_W-2:0], 1'b0} + NODE_W'(2);
      end
    end
    if (cmd.char_wr) begin
      lvl <= depth - LVL_W'(1);
    end else if (cmd.merge) begin
      lvl <= lvl - LVL_W'(1);
    end
    if (cmd.rd_b) begin
      a_reg  <= node_rd;
      cm_reg <= char_rd;
    end
    if (cmd.out_load) begin
      longest_run <= root_best;
      index_error <= err_reg;
    end
  end

  always_comb begin
    stat.op_set     = (operation != OP_CLEAR);
    stat.pos_err    = ({1'b0, position} >= len_eff);
    stat.sweep_last = (sweep_cnt == SWEEP_LAST);
    stat.leaf       = (lo == hi);
    stat.depth_zero = (depth == '0);
    stat.lvl_zero   = (lvl == '0);
    stat.out_free   = !out_valid || out_ready;
  end

endmodule
